>>> hdl/md5sh_pkg.sv
// Package for the MD5 stream hasher: payload structs, controller types,
// round constants and shift tables. No dependencies.
package md5sh_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } md5sh_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } md5sh_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_PAD,
    ST_EMIT,
    ST_FOLD
  } md5sh_state_e;

  // Commands from controller to datapath.
  typedef struct packed {
    logic       absorb;      // write a message byte into the block
    logic       start;       // load working words, round counter to zero
    logic       round;       // run one round
    logic       finish;      // add working words into chaining words
    logic       pad_fill;    // write padding into the block
    logic       pad_extra;   // padding needs its own trailing length block
    logic       rearm;       // restore initial values
  } md5sh_cmd_t;

  typedef struct packed {
    logic       block_full;  // 64 bytes held
    logic       last_round;  // round counter at 63
    logic       pad_spill;   // 0x80 lands past byte 55
  } md5sh_sts_t;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] shift_amt(input logic [3:0] i);
    logic [4:0] s;
    unique case (i)
      4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

>>> hdl/md5_stream_hasher_unit.sv
// MD5 stream hasher: takes one request per idle cycle; a request with a byte
// that fills the block runs a compression, and an end of message runs one
// padding block, or two when the 0x80 marker lands past byte 55, and then
// emits four output words. The single shared round unit runs one MD5 round
// per cycle. Uses md5sh_pkg.
module md5_stream_hasher_unit import md5sh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  md5sh_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output md5sh_out_t out_data_o
);

  md5sh_cmd_t cmd;
  md5sh_sts_t sts;
  logic [1:0] sel;
  logic [31:0] word;

  md5sh_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .has_byte_i(in_data_i.has_byte), .eom_i(in_data_i.end_of_message),
    .sts_i(sts), .cmd_o(cmd), .word_sel_o(sel), .out_valid_o, .out_stall_i
  );

  md5sh_datapath u_dp (
    .clk_i, .rst_ni, .data_byte_i(in_data_i.data_byte),
    .cmd_i(cmd), .word_sel_i(sel), .sts_o(sts), .word_o(word)
  );

  assign out_data_o.digest_word = word;
  assign out_data_o.word_index  = sel;
  assign out_data_o.last_word   = (sel == 2'd3);

endmodule

>>> hdl/md5sh_datapath.sv
// Datapath of the MD5 stream hasher: block buffer, length counter, chaining
// and working words and the one-round-per-cycle compression unit. Uses md5sh_pkg.
module md5sh_datapath import md5sh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  data_byte_i,
  input  md5sh_cmd_t  cmd_i,
  input  logic [1:0]  word_sel_i,
  output md5sh_sts_t  sts_o,
  output logic [31:0] word_o
);

  // The block is held as sixteen little-endian message words.
  logic [31:0] buf_q [16];
  logic [6:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic [31:0] h_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [5:0]  rnd_q;

  logic [1:0]  phase;
  logic [31:0] f, w, sum, rot;
  logic [3:0]  g;
  logic [4:0]  sh;
  logic [63:0] rot2;
  logic        spill;

  always_comb begin
    phase = rnd_q[5:4];
    unique case (phase)
      2'd0: begin f = (b_q & c_q) | (~b_q & d_q); g = rnd_q[3:0]; end
      2'd1: begin f = (b_q & d_q) | (c_q & ~d_q); g = 4'(5 * rnd_q + 1); end
      2'd2: begin f = b_q ^ c_q ^ d_q;            g = 4'(3 * rnd_q + 5); end
      default: begin f = c_q ^ (b_q | ~d_q);      g = 4'(7 * rnd_q); end
    endcase
    w    = buf_q[g];
    sum  = a_q + f + round_const(rnd_q) + w;
    sh   = shift_amt({phase, rnd_q[1:0]});
    rot2 = {sum, sum} << sh;
    rot  = rot2[63:32];
  end

  assign spill = (fill_q[5:0] > 6'd55);
  assign sts_o.block_full = fill_q[6];
  assign sts_o.last_round = (rnd_q == 6'd63);
  assign sts_o.pad_spill  = spill;
  assign word_o = h_q[word_sel_i];

  always_comb begin
    fill_d = fill_q;
    len_d  = len_q;
    if (cmd_i.absorb) begin
      fill_d = fill_q + 7'd1;
      len_d  = len_q + 64'd8;
    end
    if (cmd_i.finish && fill_q[6]) fill_d = '0;
    if (cmd_i.rearm) begin
      fill_d = '0;
      len_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      len_q  <= '0;
      h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
      rnd_q  <= '0;
    end else begin
      fill_q <= fill_d;
      len_q  <= len_d;
      if (cmd_i.start) rnd_q <= '0;
      else if (cmd_i.round) rnd_q <= rnd_q + 6'd1;
      if (cmd_i.rearm) begin
        h_q[0] <= InitA; h_q[1] <= InitB; h_q[2] <= InitC; h_q[3] <= InitD;
      end else if (cmd_i.finish) begin
        h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
        h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
    end else if (cmd_i.round) begin
      a_q <= d_q; d_q <= c_q; c_q <= b_q; b_q <= b_q + rot;
    end
  end

  // Padding keeps message bytes below the fill point. With pad_extra the rest
  // is 0x80 and zeros; otherwise the length goes in the top eight bytes. A
  // block holding just the length after a spill is zero below the length.
  always_ff @(posedge clk_i) begin
    if (cmd_i.absorb) buf_q[fill_q[5:2]][{fill_q[1:0], 3'd0} +: 8] <= data_byte_i;
    if (cmd_i.pad_fill) begin
      for (int i = 0; i < 64; i++) begin
        if (i < 56 || cmd_i.pad_extra) begin
          if (fill_q[6] || (spill && !cmd_i.pad_extra))
            buf_q[i[5:2]][{i[1:0], 3'd0} +: 8] <= 8'h00;
          else if (6'(i) == fill_q[5:0]) buf_q[i[5:2]][{i[1:0], 3'd0} +: 8] <= PadByte;
          else if (6'(i) > fill_q[5:0]) buf_q[i[5:2]][{i[1:0], 3'd0} +: 8] <= 8'h00;
        end else begin
          buf_q[i[5:2]][{i[1:0], 3'd0} +: 8] <= len_q[8*(i-56) +: 8];
        end
      end
    end
  end

endmodule

>>> hdl/md5sh_ctrl.sv
// Controller of the MD5 stream hasher: sequences absorb, compression rounds,
// padding and digest output. Uses md5sh_pkg.
module md5sh_ctrl import md5sh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        has_byte_i,
  input  logic        eom_i,
  input  md5sh_sts_t  sts_i,
  output md5sh_cmd_t  cmd_o,
  output logic [1:0]  word_sel_o,
  output logic        out_valid_o,
  input  logic        out_stall_i
);

  md5sh_state_e state_q, state_d;
  logic eom_q, eom_d;       // message end pending behind the current block
  logic pad_q, pad_d;       // current block is a padding block
  logic spill_q, spill_d;   // a length-only block still follows
  logic [1:0] sel_q, sel_d;

  assign word_sel_o  = sel_q;
  assign out_valid_o = (state_q == ST_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eom_q   <= 1'b0;
      pad_q   <= 1'b0;
      spill_q <= 1'b0;
      sel_q   <= '0;
    end else begin
      state_q <= state_d;
      eom_q   <= eom_d;
      pad_q   <= pad_d;
      spill_q <= spill_d;
      sel_q   <= sel_d;
    end
  end

  always_comb begin
    state_d = state_q;
    eom_d   = eom_q;
    pad_d   = pad_q;
    spill_d = spill_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.absorb = has_byte_i;
          eom_d = eom_i;
          if (has_byte_i || eom_i) state_d = ST_PAD;
        end
      end
      // Decide, after a request or after a fold, whether a block must run.
      ST_PAD: begin
        pad_d = 1'b0;
        if (sts_i.block_full) begin
          cmd_o.start = 1'b1;
          state_d = ST_RUN;
        end else if (eom_q) begin
          eom_d = 1'b0;
          cmd_o.pad_fill  = 1'b1;
          cmd_o.pad_extra = sts_i.pad_spill;
          spill_d = sts_i.pad_spill;
          pad_d = 1'b1;
          cmd_o.start = 1'b1;
          state_d = ST_RUN;
        end else if (spill_q) begin
          spill_d = 1'b0;
          cmd_o.pad_fill = 1'b1;
          pad_d = 1'b1;
          cmd_o.start = 1'b1;
          state_d = ST_RUN;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_RUN: begin
        cmd_o.round = 1'b1;
        if (sts_i.last_round) state_d = ST_FOLD;
      end
      ST_EMIT: begin
        if (!out_stall_i) begin
          sel_d = sel_q + 2'd1;
          if (sel_q == 2'd3) begin
            cmd_o.rearm = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_FOLD: begin
        // Rounds done: fold into chaining words, then pad, emit or return.
        cmd_o.finish = 1'b1;
        if (pad_q && !spill_q) begin
          sel_d = '0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PAD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for md5_stream_hasher_unit: drives byte requests,
// predicts MD5 digest words and compares them with the block's output.
// Depends on md5sh_pkg and the RTL of the hasher.
module tb_top import md5sh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  md5sh_in_t  in_data_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  md5sh_out_t out_data_o;

  md5_stream_hasher_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state.
  logic [31:0] chain_q [4];
  logic [7:0]  blk_q [64];
  int unsigned fill_q;
  logic [63:0] bits_q;
  md5sh_out_t  digest_words_q [$];
  int unsigned err_cnt = 0;
  bit          hold_rx = 1'b0;

  localparam logic [31:0] Ks [64] = '{
    32'hd76aa478,32'he8c7b756,32'h242070db,32'hc1bdceee,32'hf57c0faf,32'h4787c62a,
    32'ha8304613,32'hfd469501,32'h698098d8,32'h8b44f7af,32'hffff5bb1,32'h895cd7be,
    32'h6b901122,32'hfd987193,32'ha679438e,32'h49b40821,32'hf61e2562,32'hc040b340,
    32'h265e5a51,32'he9b6c7aa,32'hd62f105d,32'h02441453,32'hd8a1e681,32'he7d3fbc8,
    32'h21e1cde6,32'hc33707d6,32'hf4d50d87,32'h455a14ed,32'ha9e3e905,32'hfcefa3f8,
    32'h676f02d9,32'h8d2a4c8a,32'hfffa3942,32'h8771f681,32'h6d9d6122,32'hfde5380c,
    32'ha4beea44,32'h4bdecfa9,32'hf6bb4b60,32'hbebfbc70,32'h289b7ec6,32'heaa127fa,
    32'hd4ef3085,32'h04881d05,32'hd9d4d039,32'he6db99e5,32'h1fa27cf8,32'hc4ac5665,
    32'hf4292244,32'h432aff97,32'hab9423a7,32'hfc93a039,32'h655b59c3,32'h8f0ccc92,
    32'hffeff47d,32'h85845dd1,32'h6fa87e4f,32'hfe2ce6e0,32'ha3014314,32'h4e0811a1,
    32'hf7537e82,32'hbd3af235,32'h2ad7d2bb,32'heb86d391};
  localparam int Rot [16] = '{7,12,17,22,5,9,14,20,4,11,16,23,6,10,15,21};

  function automatic logic [31:0] rotl(logic [31:0] x, int n);
    return (n == 0) ? x : ((x << n) | (x >> (32 - n)));
  endfunction

  task automatic restart_digest();
    chain_q = '{InitA, InitB, InitC, InitD};
    fill_q = 0;
    bits_q = '0;
  endtask

  task automatic compress_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_q[4*i+3], blk_q[4*i+2], blk_q[4*i+1], blk_q[4*i]};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
      endcase
      t = d; d = c; c = b;
      b = b + rotl(a + f + Ks[i] + w[g], Rot[(i/16)*4 + i%4]);
      a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d;
  endtask

  // Absorbs one request and queues the digest words it produces.
  task automatic absorb_request(md5sh_in_t r);
    int k;
    md5sh_out_t o;
    if (r.has_byte) begin
      blk_q[fill_q] = r.data_byte;
      fill_q++;
      bits_q += 64'd8;
      if (fill_q == 64) begin
        compress_block();
        fill_q = 0;
      end
    end
    if (!r.end_of_message) return;
    k = fill_q;
    blk_q[k++] = PadByte;
    if (k > 56) begin
      while (k < 64) blk_q[k++] = 8'h00;
      compress_block();
      k = 0;
    end
    while (k < 56) blk_q[k++] = 8'h00;
    for (int j = 0; j < 8; j++) blk_q[56+j] = bits_q[8*j +: 8];
    compress_block();
    for (int j = 0; j < 4; j++) begin
      o.digest_word = chain_q[j];
      o.word_index = 2'(j);
      o.last_word = (j == 3);
      digest_words_q.push_back(o);
    end
    restart_digest();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Output monitor.
  always @(posedge clk_i) begin
    md5sh_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (digest_words_q.size() == 0) begin
        report_mismatch("unexpected word", out_data_o.digest_word, '0);
      end else begin
        want = digest_words_q.pop_front();
        if (out_data_o.digest_word !== want.digest_word)
          report_mismatch("digest_word", out_data_o.digest_word, want.digest_word);
        if (out_data_o.word_index !== want.word_index)
          report_mismatch("word_index", out_data_o.word_index, want.word_index);
        if (out_data_o.last_word !== want.last_word)
          report_mismatch("last_word", out_data_o.last_word, want.last_word);
      end
    end
  end

  // Receiver stall: random gaps, with one long hold-off on request.
  initial begin
    int n;
    while (1) begin
      @(posedge clk_i);
      if (hold_rx) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_rx = 1'b0;
        out_stall_i <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Sends one request and waits for acceptance; the prediction is made then.
  task automatic send_request(md5sh_in_t r, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 4) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 100) : $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    absorb_request(r);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (digest_words_q.size() != 0) @(posedge clk_i);
  endtask

  typedef struct {
    md5sh_in_t   req;
    logic [31:0] known_a;  // word a of the digest, or zero where not typed in
  } dir_row_t;

  initial begin
    dir_row_t rows [$];
    md5sh_in_t r;
    int len;
    restart_digest();
    for (int i = 0; i < 64; i++) blk_q[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty message, "a", bytes 0xFF and 0x00 among byte-less requests, empty again.
    rows.push_back('{'{8'h00, 1'b0, 1'b1}, 32'hd98c1dd4});
    rows.push_back('{'{8'h61, 1'b1, 1'b1}, 32'hb975c10c});
    rows.push_back('{'{8'hFF, 1'b1, 1'b0}, 32'h0});
    rows.push_back('{'{8'hAA, 1'b0, 1'b0}, 32'h0});
    rows.push_back('{'{8'h00, 1'b1, 1'b0}, 32'h0});
    rows.push_back('{'{8'h55, 1'b0, 1'b1}, 32'h0});
    rows.push_back('{'{8'h00, 1'b0, 1'b1}, 32'hd98c1dd4});
    foreach (rows[i]) begin
      send_request(rows[i].req, 1'b0);
      if (rows[i].known_a != 0 && digest_words_q.size() == 4
          && digest_words_q[0].digest_word !== rows[i].known_a)
        report_mismatch("typed digest a", digest_words_q[0].digest_word, rows[i].known_a);
    end
    wait_drained();

    // Lengths around the padding boundary: 55, 56 and 64 bytes.
    for (int m = 0; m < 3; m++) begin
      len = (m == 0) ? 55 : (m == 1) ? 56 : 64;
      for (int i = 0; i < len; i++) begin
        r.data_byte = 8'($urandom);
        r.has_byte = 1'b1;
        r.end_of_message = (i == len - 1) && (m != 2);
        send_request(r, 1'b1);
      end
      if (m == 2) send_request('{8'h00, 1'b0, 1'b1}, 1'b0);
    end

    // Receiver holds off while the sender keeps offering requests.
    wait_drained();
    hold_rx = 1'b1;
    for (int i = 0; i < 20; i++) begin
      r.data_byte = 8'($urandom);
      r.has_byte = 1'b1;
      r.end_of_message = (i % 5 == 4);
      send_request(r, 1'b0);
    end
    wait_drained();

    // Random messages, mostly short, now and then a long one.
    for (int cnt = 0; cnt < 65; ) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 20);
      for (int i = 0; i <= len; i++) begin
        r.data_byte = 8'($urandom);
        r.has_byte = (i < len) ? ($urandom_range(0, 9) != 0) : $urandom_range(0, 1);
        r.end_of_message = (i == len);
        send_request(r, 1'b1);
        cnt++;
      end
    end
    wait_drained();
    repeat (300) @(posedge clk_i);
    if (err_cnt == 0 && digest_words_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> sim.f
hdl/md5sh_pkg.sv
hdl/md5sh_datapath.sv
hdl/md5sh_ctrl.sv
hdl/md5_stream_hasher_unit.sv
tb/sv/tb_top.sv
